// File: rtl/sbva_pkg.sv
package sbva_pkg;

  localparam int unsigned SBVA_MAX_WIDTH = 64;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_NEG = 3'd2,
    OP_INV = 3'd3,
    OP_INC = 3'd4,
    OP_SHL = 3'd5,
    OP_ASR = 3'd6,
    OP_MUL = 3'd7
  } op_t;

  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_OVF     = 2'd1;
  localparam logic [1:0] ERR_REFUSED = 2'd2;

  localparam logic [1:0] WIDTH_MODE_RESET = 2'd2;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
    logic [5:0]         shift_amount;
  } req_t;

  typedef struct packed {
    logic signed [63:0] value_low;
    logic signed [63:0] value_high;
    logic [1:0]         error_code;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic step;
    logic fix;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic done;
  } status_t;

  // Active width 8 << mode, capped at the largest supported width.
  function automatic logic [6:0] active_width(logic [1:0] mode, int unsigned max_w);
    int unsigned w;
    w = 32'd8 << mode;
    if (w > max_w) begin
      w = max_w;
    end
    if (w < 32'd8) begin
      w = 32'd8;
    end
    if (w > 32'd64) begin
      w = 32'd64;
    end
    return w[6:0];
  endfunction

  // Sign-extend the low w bits of v to 64 bits.
  function automatic logic [63:0] sext_w(logic [63:0] v, logic [6:0] w);
    logic [63:0] mask;
    logic [6:0]  msb;
    mask = (w >= 7'd64) ? '1 : ((64'd1 << w) - 64'd1);
    msb  = w - 7'd1;
    return v[msb[5:0]] ? ((v & mask) | ~mask) : (v & mask);
  endfunction

endpackage

// File: rtl/sbva_ctrl.sv
module sbva_ctrl
  import sbva_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    done
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ITER,
    S_FIX,
    S_FIN
  } state_t;

  state_t state;

  always_comb begin
    cmd.load   = (state == S_IDLE) && start;
    cmd.step   = (state == S_ITER) && !status.done;
    cmd.fix    = (state == S_FIX);
    cmd.finish = (state == S_FIN);
    busy       = (state != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_ITER;
          end
        end
        S_ITER: begin
          if (status.done) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          state <= S_FIN;
        end
        S_FIN: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The result strobe only ever follows the finishing state.
  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_FIN))
    else $error("result strobe without a finishing step");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy while presenting a result");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the block busy");

endmodule

// File: rtl/sbva_dp.sv
module sbva_dp
  import sbva_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = SBVA_MAX_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_data,
  input  req_t       req,
  input  cmd_t       cmd,
  output status_t    status,
  output rsp_t       rsp
);

  logic [1:0]  width_mode;
  logic [6:0]  cnt;
  logic [1:0]  err;
  op_t         op;
  logic [63:0] acc;
  logic [63:0] mcand;
  logic [31:0] mplier;
  logic        neg;
  rsp_t        rsp_q;

  logic [6:0]  w;
  logic [6:0]  msb;
  logic [6:0]  msb_m1;
  logic        mul_ok;
  logic        shl_ovf;
  op_t         in_op;
  logic [63:0] a_s;
  logic [63:0] b_s;
  logic [63:0] ma;
  logic [63:0] mb;
  logic [63:0] inc_r;
  logic signed [63:0] acc_s;

  always_comb begin
    w       = active_width(width_mode, MAX_WIDTH);
    msb     = w - 7'd1;
    msb_m1  = w - 7'd2;
    mul_ok  = (w <= 7'd32) && (w < 7'(MAX_WIDTH));
    in_op   = op_t'(req.req_type);
    a_s     = sext_w(req.operand_a, w);
    b_s     = sext_w(req.operand_b, w);
    ma      = a_s[63] ? (64'd0 - a_s) : a_s;
    mb      = b_s[63] ? (64'd0 - b_s) : b_s;
    inc_r   = sext_w(a_s + 64'd1, w);
    shl_ovf = acc[msb[5:0]] != acc[msb_m1[5:0]];
    acc_s   = acc;
    status.done = (cnt == 7'd0) || (err != ERR_OK);
  end

  // Control registers: configuration, step count and error flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_mode <= WIDTH_MODE_RESET;
      cnt        <= 7'd0;
      err        <= ERR_OK;
    end else begin
      if (cfg_we) begin
        width_mode <= cfg_data;
      end
      if (cmd.load) begin
        err <= ERR_OK;
        cnt <= 7'd0;
        case (in_op)
          OP_INC: begin
            if (!a_s[63] && inc_r[63]) begin
              err <= ERR_OVF;
            end
          end
          OP_SHL, OP_ASR: begin
            cnt <= {1'b0, req.shift_amount};
          end
          OP_MUL: begin
            if (mul_ok) begin
              cnt <= w;
            end else begin
              err <= ERR_REFUSED;
            end
          end
          default: begin
          end
        endcase
      end else if (cmd.step) begin
        if (op == OP_SHL && shl_ovf) begin
          err <= ERR_OVF;
        end else begin
          cnt <= cnt - 7'd1;
        end
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= in_op;
      mcand  <= ma;
      mplier <= mb[31:0];
      neg    <= a_s[63] ^ b_s[63];
      case (in_op)
        OP_ADD:  acc <= sext_w(a_s + b_s, w);
        OP_SUB:  acc <= sext_w(a_s - b_s, w);
        OP_NEG:  acc <= sext_w(64'd0 - a_s, w);
        OP_INV:  acc <= ~a_s;
        OP_INC:  acc <= inc_r;
        OP_SHL:  acc <= a_s;
        OP_ASR:  acc <= a_s;
        OP_MUL:  acc <= 64'd0;
        default: acc <= 64'd0;
      endcase
    end else if (cmd.step) begin
      case (op)
        OP_SHL: begin
          if (!shl_ovf) begin
            acc <= acc << 1;
          end
        end
        OP_ASR: begin
          acc <= acc_s >>> 1;
        end
        OP_MUL: begin
          if (mplier[0]) begin
            acc <= acc + mcand;
          end
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
        end
        default: begin
        end
      endcase
    end else if (cmd.fix) begin
      if (op == OP_MUL && neg) begin
        acc <= 64'd0 - acc;
      end
    end
    if (cmd.finish) begin
      rsp_q.value_low  <= sext_w(acc, w);
      rsp_q.value_high <= (op == OP_MUL) ? (acc_s >>> w) : 64'sd0;
      rsp_q.error_code <= err;
    end
  end

  assign rsp = rsp_q;

  a_cnt_falls: assert property (@(posedge clk) disable iff (rst)
    !cmd.load |=> (cnt <= $past(cnt)))
    else $error("step count rose without a new request");

  a_mul_steps: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && req.req_type == OP_MUL) |=> (cnt <= 7'd32))
    else $error("multiply scheduled more steps than the operand width allows");

endmodule

// File: rtl/signed_bit_vector_alu.sv
// Channel   Direction  Handshake                        Beat
// config    in         cfg_valid / cfg_ready            cfg_data: width_mode (2 bits)
// request   in         start, taken when busy is low    req: req_t
// result    out        done, one-cycle strobe           rsp: rsp_t
//
// A request passes through load, the stepping loop, the fix and the finish states; the loop
// runs shift_amount steps for a shift that runs to the end, stops when a left shift would
// overflow, runs the active width (at most 32) steps for a multiply, and none otherwise.
// A new request is accepted in the cycle that shows the result strobe; configuration is
// held off while a request is in flight or offered. Synchronous reset sets width_mode to
// 32 bits and idles the controller. The receiver cannot stall: a result beat lasts one cycle.
module signed_bit_vector_alu
  import sbva_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = SBVA_MAX_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data,
  input  logic       start,
  input  req_t       req,
  output logic       busy,
  output logic       done,
  output rsp_t       rsp
);

  cmd_t    cmd;
  status_t status;

  // The width register only takes a beat while no request is in flight or being
  // offered, so every request sees one width from its load to its result.
  assign cfg_ready = !busy && !start;

  // The controller sequences load, the stepping loop, sign correction of the
  // product and the final result capture.
  sbva_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // The datapath holds the width register, the accumulator, the shift-add
  // multiplier registers and the registered result.
  sbva_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .req      (req),
    .cmd      (cmd),
    .status   (status),
    .rsp      (rsp)
  );

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import sbva_pkg::*;

  // The run is bounded well above the slowest correct run: about 1500 requests, each with
  // at most GAP_MAX idle cycles plus the work of the longest shift.
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned GAP_MAX      = 14;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned PHASE_ITEMS  = 180;

  logic       clk;
  logic       rst       = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_data  = WIDTH_MODE_RESET;
  logic       start     = 1'b0;
  req_t       req       = '0;
  logic       busy;
  logic       done;
  rsp_t       rsp;

  // Width setting as the block should currently hold it, and the results owed to us,
  // oldest first.
  logic [1:0]  width_mode_now = WIDTH_MODE_RESET;
  rsp_t        alu_results_due[$];
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;
  // When set, the sender issues requests with no idle cycles between them.
  bit          back_to_back   = 1'b0;

  signed_bit_vector_alu u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .start     (start),
    .req       (req),
    .busy      (busy),
    .done      (done),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Operand width selected by a width setting, capped at the package's maximum width; the
  // multiply limit is 32 bits, which is also the block's default width.
  function automatic int unsigned operand_width(logic [1:0] mode);
    int unsigned w;
    w = 8 << mode;
    if (w > SBVA_MAX_WIDTH) begin
      w = SBVA_MAX_WIDTH;
    end
    return w;
  endfunction

  function automatic logic [63:0] low_mask(int unsigned w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic logic [63:0] widen_signed(logic [63:0] v, int unsigned w);
    logic [63:0] m;
    m = low_mask(w);
    return v[w-1] ? (v | ~m) : (v & m);
  endfunction

  // Fills the bits above the active width with noise; the block must ignore them.
  function automatic logic [63:0] with_junk(logic [63:0] v, int unsigned w);
    logic [63:0] m;
    logic [63:0] noise;
    m     = low_mask(w);
    noise = {$urandom, $urandom};
    return (v & m) | (noise & ~m);
  endfunction

  // Works out the one result that a request produces under a given width setting.
  function automatic rsp_t compute_alu_result(logic [1:0] mode, req_t r);
    int unsigned        w;
    int unsigned        k;
    logic [63:0]        m;
    logic [63:0]        a;
    logic [63:0]        b;
    logic [63:0]        top;
    logic [63:0]        lo;
    logic [63:0]        hi;
    logic signed [63:0] sa;
    logic signed [63:0] sb;
    logic signed [63:0] prod;
    logic [1:0]         err;
    rsp_t               res;
    w   = operand_width(mode);
    m   = low_mask(w);
    a   = r.operand_a & m;
    b   = r.operand_b & m;
    top = 64'd1 << (w - 1);
    lo  = '0;
    hi  = '0;
    err = ERR_OK;
    case (op_t'(r.req_type))
      OP_ADD: begin
        lo = (a + b) & m;
      end
      OP_SUB: begin
        lo = (a - b) & m;
      end
      OP_NEG: begin
        lo = (64'd0 - a) & m;
      end
      OP_INV: begin
        lo = ~a & m;
      end
      OP_INC: begin
        lo = (a + 64'd1) & m;
        // Only stepping from the largest positive value into the sign bit overflows.
        if (((a & top) == 0) && ((lo & top) != 0)) begin
          err = ERR_OVF;
        end
      end
      OP_SHL: begin
        lo = a;
        for (k = 0; k < r.shift_amount; k++) begin
          // A step is refused once the next shift would change the sign.
          if (lo[w-1] != lo[w-2]) begin
            err = ERR_OVF;
            break;
          end
          lo = (lo << 1) & m;
        end
      end
      OP_ASR: begin
        lo = a;
        for (k = 0; k < r.shift_amount; k++) begin
          lo = ((lo >> 1) | (lo & top)) & m;
        end
      end
      default: begin
        if (w >= SBVA_MAX_WIDTH || w > 32) begin
          err = ERR_REFUSED;
        end else begin
          // Operands of at most 32 bits give an exact product within 64 bits.
          sa   = widen_signed(a, w);
          sb   = widen_signed(b, w);
          prod = sa * sb;
          lo   = prod & m;
          hi   = (prod >> w) & m;
        end
      end
    endcase
    res.value_low  = widen_signed(lo, w);
    res.value_high = (op_t'(r.req_type) == OP_MUL) ? widen_signed(hi, w) : 64'd0;
    res.error_code = err;
    return res;
  endfunction

  // Presents one request beat and holds it until the block takes it. The start line is
  // left high when the next request follows at once, so it is never dropped and raised
  // within one time step.
  task automatic send_request(op_t op, logic [63:0] a, logic [63:0] b, logic [5:0] sh);
    req_t        r;
    int unsigned gap;
    r.req_type     = op;
    r.operand_a    = a;
    r.operand_b    = b;
    r.shift_amount = sh;
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    alu_results_due.push_back(compute_alu_result(width_mode_now, r));
    gap = back_to_back ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops issuing and waits until every owed result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    while (alu_results_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // One configuration beat; only ever called while the block is idle.
  task automatic write_width_mode(logic [1:0] mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    width_mode_now = mode;
    cfg_valid <= 1'b0;
  endtask

  // Results are sampled at the clock edge, before the block updates its outputs.
  always @(posedge clk) begin : check_results
    rsp_t want;
    if (!rst && done) begin
      if (alu_results_due.size() == 0) begin
        $error("result beat arrived with no request outstanding");
        mismatches++;
      end else begin
        want = alu_results_due.pop_front();
        if (rsp.value_low !== want.value_low) begin
          $error("value_low: expected %h, got %h", want.value_low, rsp.value_low);
          mismatches++;
        end
        if (rsp.value_high !== want.value_high) begin
          $error("value_high: expected %h, got %h", want.value_high, rsp.value_high);
          mismatches++;
        end
        if (rsp.error_code !== want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code, rsp.error_code);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Straight after reset the block should work at 32 bits, where the multiply is allowed
  // and the 32-bit add wraps.
  task automatic test_reset_width();
    send_request(OP_ADD, with_junk(64'h7fff_ffff, 32), 64'd1, '0);
    send_request(OP_MUL, with_junk(64'h8000_0000, 32), with_junk(64'h8000_0000, 32), '0);
    send_request(OP_MUL, 64'hffff_ffff_ffff_ffff, 64'd7, '0);
    wait_drained();
  endtask

  // Edge cases of every operation at the narrowest width, with noise above bit 7.
  task automatic test_directed_narrow();
    write_width_mode(2'd0);
    send_request(OP_ADD, with_junk(64'h7f, 8), with_junk(64'h7f, 8), '0);
    send_request(OP_ADD, with_junk(64'h80, 8), with_junk(64'h80, 8), '0);
    send_request(OP_SUB, with_junk(64'h80, 8), with_junk(64'h01, 8), '0);
    // Subtracting zero and negating zero must both give plain results.
    send_request(OP_SUB, with_junk(64'h05, 8), with_junk(64'h00, 8), '0);
    send_request(OP_NEG, with_junk(64'h00, 8), '0, '0);
    send_request(OP_NEG, with_junk(64'h80, 8), '0, '0);
    send_request(OP_INV, with_junk(64'h5a, 8), '0, 6'h3f);
    send_request(OP_INC, with_junk(64'h7f, 8), '0, '0);
    send_request(OP_INC, with_junk(64'hff, 8), '0, '0);
    send_request(OP_SHL, with_junk(64'h01, 8), '0, 6'd63);
    send_request(OP_SHL, with_junk(64'h00, 8), '0, 6'd63);
    send_request(OP_SHL, with_junk(64'h40, 8), '0, 6'd1);
    send_request(OP_SHL, with_junk(64'hc3, 8), '0, 6'd0);
    send_request(OP_ASR, with_junk(64'h80, 8), '0, 6'd63);
    send_request(OP_ASR, with_junk(64'h7f, 8), '0, 6'd3);
    send_request(OP_MUL, with_junk(64'h80, 8), with_junk(64'h80, 8), '0);
    send_request(OP_MUL, with_junk(64'hff, 8), with_junk(64'h01, 8), '0);
    send_request(OP_MUL, with_junk(64'h00, 8), with_junk(64'h80, 8), '0);
    send_request(OP_MUL, with_junk(64'h7f, 8), with_junk(64'h81, 8), '0);
    wait_drained();
  endtask

  // At full width the multiply is refused and the extremes reach bit 63.
  task automatic test_directed_wide();
    write_width_mode(2'd3);
    send_request(OP_MUL, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, '0);
    send_request(OP_INC, 64'h7fff_ffff_ffff_ffff, '0, '0);
    send_request(OP_NEG, 64'h8000_0000_0000_0000, '0, '0);
    send_request(OP_ASR, 64'h8000_0000_0000_0000, '0, 6'd63);
    send_request(OP_SUB, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, '0);
    wait_drained();
  endtask

  function automatic logic [63:0] random_operand(int unsigned w);
    logic [63:0] m;
    logic [63:0] v;
    int          small_val;
    m = low_mask(w);
    case ($urandom_range(0, 7))
      0, 1: begin
        v = {$urandom, $urandom};
      end
      2: begin
        // Largest, most negative, zero, minus one or one.
        case ($urandom_range(0, 4))
          0:       v = (m >> 1);
          1:       v = ~(m >> 1) & m;
          2:       v = '0;
          3:       v = m;
          default: v = 64'd1;
        endcase
        v = with_junk(v, w);
      end
      3: begin
        // Small magnitudes let left shifts run many steps before overflowing.
        small_val = int'($urandom_range(0, 32)) - 16;
        v = with_junk(64'(small_val), w);
      end
      4: begin
        v = with_junk(64'd1 << $urandom_range(0, w - 1), w);
      end
      default: begin
        v = with_junk({$urandom, $urandom}, w);
      end
    endcase
    return v;
  endfunction

  function automatic logic [5:0] random_shift(int unsigned w);
    int unsigned s;
    case ($urandom_range(0, 3))
      0:       s = $urandom_range(0, 63);
      1:       s = $urandom_range(0, 7);
      2:       s = w - 1 + $urandom_range(0, 2);
      default: s = $urandom_range(0, w);
    endcase
    return (s > 63) ? 6'd63 : s[5:0];
  endfunction

  // Random requests of every kind in phases at each width, narrowest and widest
  // included, with the width changed only once the block has drained.
  task automatic test_random_mix();
    logic [1:0]  phase_modes [8];
    int unsigned w;
    phase_modes = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1};
    foreach (phase_modes[p]) begin
      write_width_mode(phase_modes[p]);
      w = operand_width(phase_modes[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Every so often switch between spaced and back-to-back request beats.
        if (i % 30 == 0) begin
          back_to_back = ($urandom_range(0, 3) == 0);
        end
        send_request(op_t'($urandom_range(0, 7)), random_operand(w), random_operand(w),
                     random_shift(w));
      end
      back_to_back = 1'b0;
      wait_drained();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_width();
    test_directed_narrow();
    test_directed_wide();
    test_random_mix();
    // Allow a stray late beat to show itself before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
